### hw/rtl/tsdf_pkg.sv
// Package for the text stream display formatter.
// Holds the format mode type, the command codes and the character constants.
// Used by every module of the block; depends on nothing.
package tsdf_pkg;

    localparam int DEF_NUMBER_DIGITS = 6;

    typedef enum logic [2:0] {
        MODE_PLAIN        = 3'd0,
        MODE_NUM_NONBLANK = 3'd1,
        MODE_ENDS_CARET   = 3'd2,
        MODE_NUM_ALL      = 3'd3,
        MODE_SQUEEZE      = 3'd4,
        MODE_TABS_CARET   = 3'd5,
        MODE_ENDS         = 3'd6,
        MODE_TABS         = 3'd7
    } t_mode;

    typedef logic [7:0] t_byte;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_EOF  = 1'b1;

    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_NL     = 8'h0A;
    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_QMARK  = 8'h3F;
    localparam t_byte CH_AT     = 8'h40;
    localparam t_byte CH_I      = 8'h49;
    localparam t_byte CH_CARET  = 8'h5E;
    localparam t_byte CH_DEL    = 8'h7F;

endpackage

### hw/rtl/text_stream_display_formatter.sv
// Text stream display formatter, top level: input register, mode register,
// formatting stage and result register. Depends on tsdf_pkg, tsdf_format, tsdf_burst.
//
// Usage: each input transfer on i_in_valid/o_in_ready carries one text byte or,
// with i_command high, an end-of-file marker. Formatted bytes leave one per
// transfer on o_out_valid/i_out_ready; o_last_of_run marks the final byte
// caused by an input. The format mode is written through i_cfg_wr_en and
// i_cfg_wr_data; the user must write it only while the block is idle (the block
// itself does not enforce this), and it applies from the next byte. An accepted
// item waits in the input register until the result register is free, is then
// formatted into the result register, and its first byte is offered from there.
// Throughput: one item per cycle while each item yields one byte and the
// receiver is ready; an item yielding N bytes (at most NUMBER_DIGITS+2) holds
// the result register for N transfers, and the shift-out of that burst sets the
// rate. An item that yields no byte leaves the result register free for the next.
// When the receiver stalls, the result register holds its bytes, the input
// register fills and o_in_ready falls until room frees up. Reset selects plain
// mode, sets the line number to one, clears the line state and empties both registers.
module text_stream_display_formatter
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int CW = $clog2(NUMBER_DIGITS + 3);

    t_mode         r_mode;
    logic          r_in_valid;
    logic          r_command;
    t_byte         r_data_byte;
    logic          step;
    logic          burst_free;
    t_byte         fmt_bytes [NUMBER_DIGITS + 2];
    logic [CW-1:0] fmt_count;

    assign step       = r_in_valid && burst_free;
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_PLAIN;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= t_mode'(i_cfg_wr_data);
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_command   <= i_command;
            r_data_byte <= i_data_byte;
        end
    end

    tsdf_format #(
        .NUMBER_DIGITS (NUMBER_DIGITS),
        .CW            (CW)
    ) u_format (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_mode      (r_mode),
        .i_command   (r_command),
        .i_data_byte (r_data_byte),
        .o_bytes     (fmt_bytes),
        .o_count     (fmt_count)
    );

    tsdf_burst #(
        .NUMBER_DIGITS (NUMBER_DIGITS),
        .CW            (CW)
    ) u_burst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (step),
        .i_bytes       (fmt_bytes),
        .i_count       (fmt_count),
        .o_free        (burst_free),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

endmodule

### hw/rtl/tsdf_format.sv
// Formatting stage: holds the line state and turns one registered item into a
// burst of output bytes with its length.
// Depends on tsdf_pkg.
module tsdf_format
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS,
    parameter int CW            = $clog2(NUMBER_DIGITS + 3)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  t_mode           i_mode,
    input  logic            i_command,
    input  t_byte           i_data_byte,
    output t_byte           o_bytes [NUMBER_DIGITS + 2],
    output logic [CW-1:0]   o_count
);

    localparam int NW = 4 * NUMBER_DIGITS;
    localparam logic [NW-1:0] LINE_ONE = NW'(1);

    logic [NW-1:0] r_line;
    logic          r_at_start;
    logic          r_prev_blank;
    logic          r_seen;

    logic [NW-1:0] n_line;
    logic          n_at_start;
    logic          n_prev_blank;
    logic          n_seen;

    logic [NW-1:0] line_inc;
    t_byte         num_chars [NUMBER_DIGITS];
    logic          is_ctl;
    logic          is_nl;
    logic          is_tab;
    logic          prefix;
    t_byte         caret_char;

    // Decimal text of the line number, most significant digit first.
    always_comb begin
        logic any_nz;
        any_nz = 1'b0;
        for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
            any_nz = any_nz | (r_line[4*i +: 4] != 4'd0);
            if (!any_nz && i != 0) begin
                num_chars[NUMBER_DIGITS - 1 - i] = CH_SPACE;
            end else begin
                num_chars[NUMBER_DIGITS - 1 - i] = CH_ZERO + {4'd0, r_line[4*i +: 4]};
            end
        end
    end

    // Saturating BCD increment.
    always_comb begin
        logic carry;
        logic nines;
        carry    = 1'b1;
        nines    = 1'b1;
        line_inc = r_line;
        for (int i = 0; i < NUMBER_DIGITS; i++) begin
            nines = nines & (r_line[4*i +: 4] == 4'd9);
            if (carry) begin
                if (r_line[4*i +: 4] == 4'd9) begin
                    line_inc[4*i +: 4] = 4'd0;
                end else begin
                    line_inc[4*i +: 4] = r_line[4*i +: 4] + 4'd1;
                    carry              = 1'b0;
                end
            end
        end
        if (nines) begin
            line_inc = r_line;
        end
    end

    assign is_nl      = (i_data_byte == CH_NL);
    assign is_tab     = (i_data_byte == CH_TAB);
    assign is_ctl     = (i_data_byte < CH_SPACE) || (i_data_byte == CH_DEL);
    assign caret_char = (i_data_byte == CH_DEL) ? CH_QMARK : (CH_AT + i_data_byte);

    always_comb begin
        for (int k = 0; k < NUMBER_DIGITS + 2; k++) begin
            o_bytes[k] = i_data_byte;
        end
        o_count = CW'(1);
        prefix  = 1'b0;
        if (i_command == CMD_EOF) begin
            o_count = '0;
            if (i_mode == MODE_NUM_ALL && !r_seen) begin
                for (int k = 0; k < NUMBER_DIGITS; k++) begin
                    o_bytes[k] = num_chars[k];
                end
                o_bytes[NUMBER_DIGITS] = CH_TAB;
                o_count = CW'(NUMBER_DIGITS + 1);
            end
        end else begin
            case (i_mode)
                MODE_NUM_NONBLANK: begin
                    prefix = r_at_start && !is_nl;
                end
                MODE_NUM_ALL: begin
                    prefix = r_at_start;
                end
                MODE_ENDS_CARET: begin
                    if (is_nl) begin
                        o_bytes[0] = CH_DOLLAR;
                        o_bytes[1] = CH_NL;
                        o_count    = CW'(2);
                    end else if (is_ctl && !is_tab) begin
                        o_bytes[0] = CH_CARET;
                        o_bytes[1] = caret_char;
                        o_count    = CW'(2);
                    end
                end
                MODE_SQUEEZE: begin
                    if (is_nl && r_at_start && r_prev_blank) begin
                        o_count = '0;
                    end
                end
                MODE_TABS_CARET: begin
                    if (is_tab) begin
                        o_bytes[0] = CH_CARET;
                        o_bytes[1] = CH_I;
                        o_count    = CW'(2);
                    end else if (is_ctl && !is_nl) begin
                        o_bytes[0] = CH_CARET;
                        o_bytes[1] = caret_char;
                        o_count    = CW'(2);
                    end
                end
                MODE_ENDS: begin
                    if (is_nl) begin
                        o_bytes[0] = CH_DOLLAR;
                        o_bytes[1] = CH_NL;
                        o_count    = CW'(2);
                    end
                end
                MODE_TABS: begin
                    if (is_tab) begin
                        o_bytes[0] = CH_CARET;
                        o_bytes[1] = CH_I;
                        o_count    = CW'(2);
                    end
                end
                default: begin
                    o_count = CW'(1);
                end
            endcase
            if (prefix) begin
                for (int k = 0; k < NUMBER_DIGITS; k++) begin
                    o_bytes[k] = num_chars[k];
                end
                o_bytes[NUMBER_DIGITS]     = CH_TAB;
                o_bytes[NUMBER_DIGITS + 1] = i_data_byte;
                o_count = CW'(NUMBER_DIGITS + 2);
            end
        end
    end

    always_comb begin
        n_line       = r_line;
        n_at_start   = r_at_start;
        n_prev_blank = r_prev_blank;
        n_seen       = r_seen;
        if (i_step) begin
            if (i_command == CMD_EOF) begin
                n_line       = LINE_ONE;
                n_at_start   = 1'b1;
                n_prev_blank = 1'b0;
                n_seen       = 1'b0;
            end else begin
                n_line       = prefix ? line_inc : r_line;
                n_at_start   = is_nl;
                n_prev_blank = is_nl && r_at_start;
                n_seen       = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line       <= LINE_ONE;
            r_at_start   <= 1'b1;
            r_prev_blank <= 1'b0;
            r_seen       <= 1'b0;
        end else begin
            r_line       <= n_line;
            r_at_start   <= n_at_start;
            r_prev_blank <= n_prev_blank;
            r_seen       <= n_seen;
        end
    end

endmodule

### hw/rtl/tsdf_burst.sv
// Result register: holds one burst of formatted bytes and hands them out one
// transfer at a time through a shift line. Depends on tsdf_pkg.
module tsdf_burst
    import tsdf_pkg::*;
#(
    parameter int NUMBER_DIGITS = DEF_NUMBER_DIGITS,
    parameter int CW            = $clog2(NUMBER_DIGITS + 3)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  t_byte           i_bytes [NUMBER_DIGITS + 2],
    input  logic [CW-1:0]   i_count,
    output logic            o_free,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output t_byte           o_out_byte,
    output logic            o_last_of_run
);

    localparam int NB = NUMBER_DIGITS + 2;

    t_byte         r_bytes [NB];
    logic [CW-1:0] r_count;
    t_byte         n_bytes [NB];
    logic [CW-1:0] n_count;
    logic          take;

    assign o_out_valid   = (r_count != '0);
    assign o_last_of_run = (r_count == CW'(1));
    assign o_out_byte    = r_bytes[0];
    assign take          = o_out_valid && i_out_ready;
    assign o_free        = !o_out_valid || (o_last_of_run && i_out_ready);

    always_comb begin
        n_bytes = r_bytes;
        n_count = r_count;
        if (i_load) begin
            n_bytes = i_bytes;
            n_count = i_count;
        end else if (take) begin
            for (int k = 0; k < NB - 1; k++) begin
                n_bytes[k] = r_bytes[k + 1];
            end
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

endmodule

### test/testbench.sv
// Self-checking testbench for text_stream_display_formatter: drives byte and end-of-file
// transfers in every format mode and checks each output byte against a local predictor.
// Depends on tsdf_pkg and the text_stream_display_formatter RTL.
`timescale 1ns / 100ps

module testbench;
    import tsdf_pkg::*;

    localparam int NUM_DIGITS  = DEF_NUMBER_DIGITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_CHARS = 39;
    localparam logic [4*NUM_DIGITS-1:0] LINE_ONE = (4*NUM_DIGITS)'(1);

    typedef struct packed {
        logic  cmd;
        t_byte data;
    } t_char_item;

    typedef struct packed {
        t_byte out_byte;
        logic  last;
    } t_text_beat;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [2:0] i_cfg_wr_data = 3'd0;
    logic       i_in_valid    = 1'b0;
    logic       i_command     = CMD_DATA;
    logic [7:0] i_data_byte   = 8'd0;
    logic       i_out_ready   = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_last_of_run;

    text_stream_display_formatter i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run)
    );

    t_char_item queued_chars[$];
    t_text_beat expected_text[$];
    t_byte      run_buf[$];

    t_mode                   fmt_mode        = MODE_PLAIN;
    logic [4*NUM_DIGITS-1:0] line_bcd        = LINE_ONE;
    logic                    line_start      = 1'b1;
    logic                    last_line_blank = 1'b0;
    logic                    seen_char       = 1'b0;

    int   error_count  = 0;
    int   result_count = 0;
    int   cycle_count  = 0;
    int   in_gap_max   = 12;
    int   out_gap_max  = 12;
    int   in_wait      = 0;
    int   out_wait     = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;
    logic in_taken     = 1'b0;
    logic out_taken    = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic put_byte(input t_byte b);
        run_buf.push_back(b);
    endtask

    task automatic put_caret(input t_byte c);
        put_byte(CH_CARET);
        put_byte(c == CH_DEL ? CH_QMARK : CH_AT + c);
    endtask

    task automatic put_number();
        logic       lead;
        logic [3:0] digit;
        lead = 1'b1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            digit = line_bcd[4*i +: 4];
            if (digit != 4'd0 || i == 0) begin
                lead = 1'b0;
            end
            put_byte(lead ? CH_SPACE : CH_ZERO + digit);
        end
        put_byte(CH_TAB);
    endtask

    task automatic bump_line();
        logic [3:0] digit;
        logic       carry;
        carry = (line_bcd != {NUM_DIGITS{4'h9}});
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (carry) begin
                digit = line_bcd[4*i +: 4] + 4'd1;
                if (digit == 4'd10) begin
                    line_bcd[4*i +: 4] = 4'd0;
                end else begin
                    line_bcd[4*i +: 4] = digit;
                    carry = 1'b0;
                end
            end
        end
    endtask

    task automatic format_char(input logic cmd, input t_byte c);
        logic       ctl;
        logic       nl;
        t_text_beat beat;
        ctl = (c < CH_SPACE) || (c == CH_DEL);
        nl  = (c == CH_NL);
        run_buf.delete();
        if (cmd == CMD_EOF) begin
            if (fmt_mode == MODE_NUM_ALL && !seen_char) begin
                put_number();
            end
            line_bcd        = LINE_ONE;
            line_start      = 1'b1;
            last_line_blank = 1'b0;
            seen_char       = 1'b0;
        end else begin
            case (fmt_mode)
                MODE_NUM_NONBLANK: begin
                    if (line_start && !nl) begin
                        put_number();
                        bump_line();
                    end
                    put_byte(c);
                end
                MODE_ENDS_CARET: begin
                    if (nl) begin
                        put_byte(CH_DOLLAR);
                        put_byte(CH_NL);
                    end else if (ctl && c != CH_TAB) begin
                        put_caret(c);
                    end else begin
                        put_byte(c);
                    end
                end
                MODE_NUM_ALL: begin
                    if (line_start) begin
                        put_number();
                        bump_line();
                    end
                    put_byte(c);
                end
                MODE_SQUEEZE: begin
                    if (!(nl && line_start && last_line_blank)) begin
                        put_byte(c);
                    end
                end
                MODE_TABS_CARET: begin
                    if (c == CH_TAB) begin
                        put_byte(CH_CARET);
                        put_byte(CH_I);
                    end else if (ctl && !nl) begin
                        put_caret(c);
                    end else begin
                        put_byte(c);
                    end
                end
                MODE_ENDS: begin
                    if (nl) begin
                        put_byte(CH_DOLLAR);
                        put_byte(CH_NL);
                    end else begin
                        put_byte(c);
                    end
                end
                MODE_TABS: begin
                    if (c == CH_TAB) begin
                        put_byte(CH_CARET);
                        put_byte(CH_I);
                    end else begin
                        put_byte(c);
                    end
                end
                default: begin
                    put_byte(c);
                end
            endcase
            last_line_blank = nl && line_start;
            line_start      = nl;
            seen_char       = 1'b1;
        end
        foreach (run_buf[i]) begin
            beat.out_byte = run_buf[i];
            beat.last     = (i == run_buf.size() - 1);
            expected_text.push_back(beat);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_text_beat beat;
        cycle_count <= cycle_count + 1;
        in_taken  <= i_rst_n && i_in_valid && o_in_ready;
        out_taken <= i_rst_n && o_out_valid && i_out_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            format_char(i_command, i_data_byte);
        end
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            result_count <= result_count + 1;
            if (expected_text.size() == 0) begin
                $error("out_byte: expected nothing, got %0h", o_out_byte);
                error_count = error_count + 1;
            end else begin
                beat = expected_text.pop_front();
                if (o_out_byte !== beat.out_byte) begin
                    $error("out_byte: expected %0h, got %0h", beat.out_byte, o_out_byte);
                    error_count = error_count + 1;
                end
                if (o_last_of_run !== beat.last) begin
                    $error("last_of_run: expected %0b, got %0b", beat.last, o_last_of_run);
                    error_count = error_count + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin : char_driver
        t_char_item item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
        end else if (in_wait > 0) begin
            i_in_valid <= 1'b0;
            in_wait    <= in_wait - 1;
        end else if (queued_chars.size() > 0) begin
            item = queued_chars.pop_front();
            i_in_valid  <= 1'b1;
            i_command   <= item.cmd;
            i_data_byte <= item.data;
            in_wait     <= $urandom_range(0, in_gap_max);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // A single long hold-off lets the input side fill up and stall.
    always @(negedge i_clk) begin : text_receiver
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (!hold_done && result_count >= 300 && queued_chars.size() > 10) begin
            i_out_ready <= 1'b0;
            hold_left   <= 300;
            hold_done   <= 1'b1;
        end else if (i_out_ready && !out_taken) begin
        end else if (out_wait > 0) begin
            i_out_ready <= 1'b0;
            out_wait    <= out_wait - 1;
        end else begin
            i_out_ready <= 1'b1;
            out_wait    <= $urandom_range(0, out_gap_max);
        end
    end

    task automatic send_char(input logic cmd, input t_byte c);
        t_char_item item;
        item.cmd  = cmd;
        item.data = c;
        queued_chars.push_back(item);
    endtask

    task automatic wait_idle();
        while (queued_chars.size() != 0 || i_in_valid || expected_text.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_mode(input t_mode m);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        fmt_mode = m;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_text(input int count);
        int n;
        int pick;
        int run;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_char(CMD_DATA, t_byte'($urandom_range(CH_SPACE, CH_DEL - 1)));
            end else if (pick < 60) begin
                send_char(CMD_DATA, CH_NL);
            end else if (pick < 68) begin
                send_char(CMD_DATA, CH_TAB);
            end else if (pick < 76) begin
                send_char(CMD_DATA, t_byte'($urandom_range(0, CH_SPACE - 1)));
            end else if (pick < 80) begin
                send_char(CMD_DATA, CH_DEL);
            end else if (pick < 88) begin
                send_char(CMD_DATA, t_byte'($urandom_range(CH_DEL + 1, 255)));
            end else if (pick < 93) begin
                send_char(CMD_DATA, t_byte'($urandom_range(0, 255)));
            end else if (pick < 96) begin
                send_char(CMD_EOF, t_byte'($urandom_range(0, 255)));
            end else begin
                run = $urandom_range(2, 5);
                repeat (run) send_char(CMD_DATA, CH_NL);
                n = n + run - 1;
            end
            n = n + 1;
        end
    endtask

    initial begin : stimulus
        t_byte specials[5];
        specials = '{8'h00, CH_TAB, CH_NL, CH_DEL, 8'hFF};
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_mode(MODE_NUM_ALL);
        send_char(CMD_EOF, 8'h00);
        send_char(CMD_DATA, "a");
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_EOF, 8'hFF);

        set_mode(MODE_NUM_NONBLANK);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, "b");
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_EOF, 8'h00);

        set_mode(MODE_ENDS_CARET);
        foreach (specials[i]) send_char(CMD_DATA, specials[i]);
        set_mode(MODE_TABS_CARET);
        foreach (specials[i]) send_char(CMD_DATA, specials[i]);

        set_mode(MODE_SQUEEZE);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, "x");
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_DATA, CH_NL);
        send_char(CMD_EOF, 8'h00);

        for (int p = 0; p < 10; p++) begin
            set_mode(p < 8 ? t_mode'(p) : t_mode'($urandom_range(0, 7)));
            in_gap_max  = (p == 2) ? 0 : 12;
            out_gap_max = (p == 2 || p == 6) ? 0 : 12;
            queue_text(PHASE_CHARS);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/tsdf_pkg.sv
hw/rtl/tsdf_format.sv
hw/rtl/tsdf_burst.sv
hw/rtl/text_stream_display_formatter.sv
test/testbench.sv
